/* rtl/core/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, header layout and controller/datapath command types for
// the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int HEAP_BYTES   = 65536;
  localparam int HEADER_BYTES = 12;
  localparam int ADDR_W       = 16;
  localparam int SIZE_W       = 17;
  localparam int HDR_W        = SIZE_W + 1 + ADDR_W;

  // operation codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              free;
    logic [ADDR_W-1:0] next;
  } hdr_t;

  typedef enum logic {
    RD_CUR,
    RD_NEXT
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_SPLIT,
    WR_TAKE,
    WR_SHRINK,
    WR_FREE
  } wr_sel_e;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    adv;
    logic    hold_en;
    logic    acc_en;
    logic    grant_set;
    logic    fail_set;
    logic    res_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] in_op;
    logic [1:0] op;
    logic       free_ok;
    logic       fit;
    logic       split_ok;
    logic       last;
  } sts_t;

endpackage

/* rtl/core/ffha_in_if.sv */
// ----------------------------------------------------------------------------
// ffha_in_if
// Request channel: operation, requested size and address to release.
// ----------------------------------------------------------------------------
interface ffha_in_if;
  import ffha_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [ADDR_W-1:0] request_size;
  logic [ADDR_W-1:0] payload_address;

  modport source (output valid, op, request_size, payload_address, input ready);
  modport sink   (input valid, op, request_size, payload_address, output ready);
endinterface

/* rtl/core/ffha_out_if.sv */
// ----------------------------------------------------------------------------
// ffha_out_if
// Response channel: granted address, no-space flag and free byte count.
// ----------------------------------------------------------------------------
interface ffha_out_if;
  import ffha_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] granted_address;
  logic              no_space;
  logic [SIZE_W-1:0] free_bytes;

  modport source (output valid, granted_address, no_space, free_bytes, input ready);
  modport sink   (input valid, granted_address, no_space, free_bytes, output ready);
endinterface

/* rtl/core/ffha_ram.sv */
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* rtl/core/ffha_dp.sv */
// ----------------------------------------------------------------------------
// ffha_dp
// Datapath: header memory, walk pointer, split/merge arithmetic, free byte
// accumulator and the response register.
// ----------------------------------------------------------------------------
module ffha_dp import ffha_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [1:0]        op_i,
  input  logic [ADDR_W-1:0] request_size_i,
  input  logic [ADDR_W-1:0] payload_address_i,
  output logic [ADDR_W-1:0] granted_address_o,
  output logic              no_space_o,
  output logic [SIZE_W-1:0] free_bytes_o
);

  logic [1:0]        op_q;
  logic [ADDR_W-1:0] cur_q;
  logic [SIZE_W-1:0] need_q;
  hdr_t              hold_q;
  logic [SIZE_W-1:0] acc_q;
  logic [ADDR_W-1:0] grant_q;
  logic              fail_q;
  logic [ADDR_W-1:0] rd_addr_q;
  logic              hdr0_wr_q;
  logic [ADDR_W-1:0] res_addr_q;
  logic              res_fail_q;
  logic [SIZE_W-1:0] res_free_q;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  hdr_t              ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [HDR_W-1:0]  ram_rdata;
  hdr_t              rd_hdr;
  hdr_t              nx_hdr;
  logic              nx_free;
  logic [SIZE_W:0]   split_sum;
  logic [SIZE_W-1:0] rest;
  logic [SIZE_W:0]   merge_sum;
  logic [SIZE_W-1:0] merge_sat;
  logic [SIZE_W:0]   acc_sum;

  localparam logic [SIZE_W-1:0] HeapSize = SIZE_W'(HEAP_BYTES);
  localparam logic [SIZE_W-1:0] HdrSize  = SIZE_W'(HEADER_BYTES);

  ffha_ram #(
    .Width(HDR_W),
    .Depth(HEAP_BYTES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // header zero reads as the whole heap until it is first written
  always_comb begin
    rd_hdr = hdr_t'(ram_rdata);
    if (rd_addr_q == '0 && !hdr0_wr_q) begin
      rd_hdr.size = HeapSize;
      rd_hdr.free = 1'b1;
      rd_hdr.next = '0;
    end
  end

  assign ram_raddr = (cmd_i.rd_sel == RD_NEXT) ? rd_hdr.next : cur_q;

  // fit and split arithmetic
  assign split_sum = {2'b00, cur_q} + {1'b0, need_q};
  assign rest      = rd_hdr.size - need_q;

  // merge target: the block itself when it links to itself
  assign nx_hdr    = (hold_q.next == cur_q) ? hold_q : rd_hdr;
  assign nx_free   = (hold_q.next == cur_q) ? 1'b1 : rd_hdr.free;
  assign merge_sum = {1'b0, hold_q.size} + {1'b0, nx_hdr.size};
  assign merge_sat = (merge_sum > {1'b0, HeapSize}) ? HeapSize : merge_sum[SIZE_W-1:0];

  assign acc_sum = {1'b0, acc_q} + {1'b0, rd_hdr.size};

  // write port selection
  always_comb begin
    ram_we    = cmd_i.wr_en;
    ram_waddr = cur_q;
    ram_wdata = rd_hdr;
    case (cmd_i.wr_sel)
      WR_SPLIT: begin
        ram_waddr      = split_sum[ADDR_W-1:0];
        ram_wdata.size = rest;
        ram_wdata.free = 1'b1;
        ram_wdata.next = rd_hdr.next;
      end
      WR_TAKE: begin
        ram_wdata.free = 1'b0;
      end
      WR_SHRINK: begin
        ram_wdata.size = need_q;
        ram_wdata.free = 1'b0;
        ram_wdata.next = split_sum[ADDR_W-1:0];
      end
      WR_FREE: begin
        ram_wdata.free = 1'b1;
        if (hold_q.next != '0 && nx_free) begin
          ram_wdata.size = merge_sat;
          ram_wdata.next = nx_hdr.next;
        end else begin
          ram_wdata.size = hold_q.size;
          ram_wdata.next = hold_q.next;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // status to the controller
  always_comb begin
    sts_o.in_op    = op_i;
    sts_o.op       = op_q;
    sts_o.free_ok  = payload_address_i >= ADDR_W'(HEADER_BYTES);
    sts_o.fit      = rd_hdr.free && (rd_hdr.size >= need_q);
    sts_o.split_ok = (rest > HdrSize) && (split_sum[SIZE_W:ADDR_W] == '0);
    sts_o.last     = (rd_hdr.next == '0) || (rd_hdr.next <= cur_q);
  end

  // control state of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr0_wr_q <= 1'b0;
      op_q      <= OP_ALLOC;
    end else begin
      if (ram_we && ram_waddr == '0) begin
        hdr0_wr_q <= 1'b1;
      end
      if (cmd_i.load) begin
        op_q <= op_i;
      end
    end
  end

  // walk and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_addr_q <= ram_raddr;
    end
    if (cmd_i.load) begin
      cur_q   <= (op_i == OP_FREE) ? payload_address_i - ADDR_W'(HEADER_BYTES) : '0;
      need_q  <= {1'b0, request_size_i} + HdrSize;
      acc_q   <= '0;
      grant_q <= '0;
      fail_q  <= 1'b0;
    end
    if (cmd_i.adv) begin
      cur_q <= rd_hdr.next;
    end
    if (cmd_i.hold_en) begin
      hold_q <= rd_hdr;
    end
    if (cmd_i.acc_en && rd_hdr.free) begin
      acc_q <= (acc_sum > {1'b0, HeapSize}) ? HeapSize : acc_sum[SIZE_W-1:0];
    end
    if (cmd_i.grant_set) begin
      grant_q <= cur_q + ADDR_W'(HEADER_BYTES);
    end
    if (cmd_i.fail_set) begin
      fail_q <= 1'b1;
    end
    if (cmd_i.res_load) begin
      res_addr_q <= grant_q;
      res_fail_q <= fail_q;
      res_free_q <= acc_q;
    end
  end

  assign granted_address_o = res_addr_q;
  assign no_space_o        = res_fail_q;
  assign free_bytes_o      = res_free_q;

endmodule

/* rtl/core/ffha_ctrl.sv */
// ----------------------------------------------------------------------------
// ffha_ctrl
// Controller: sequences header reads and writes for allocate, free and query,
// and runs the request and response handshakes.
// ----------------------------------------------------------------------------
module ffha_ctrl import ffha_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_AE   = 3'd2;
  localparam logic [2:0] S_AW   = 3'd3;
  localparam logic [2:0] S_QE   = 3'd4;
  localparam logic [2:0] S_FH   = 3'd5;
  localparam logic [2:0] S_FM   = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.in_op == OP_ALLOC || sts_i.in_op == OP_QUERY) begin
            state_d = S_RD;
          end else if (sts_i.in_op == OP_FREE && sts_i.free_ok) begin
            state_d = S_RD;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_CUR;
        if (sts_i.op == OP_QUERY) begin
          state_d = S_QE;
        end else if (sts_i.op == OP_FREE) begin
          state_d = S_FH;
        end else begin
          state_d = S_AE;
        end
      end
      S_AE: begin
        if (sts_i.fit) begin
          cmd_o.grant_set = 1'b1;
          cmd_o.wr_en     = 1'b1;
          if (sts_i.split_ok) begin
            cmd_o.wr_sel = WR_SPLIT;
            state_d      = S_AW;
          end else begin
            cmd_o.wr_sel = WR_TAKE;
            state_d      = S_OUT;
          end
        end else if (sts_i.last) begin
          cmd_o.fail_set = 1'b1;
          state_d        = S_OUT;
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = S_RD;
        end
      end
      S_AW: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_SHRINK;
        state_d      = S_OUT;
      end
      S_QE: begin
        cmd_o.acc_en = 1'b1;
        if (sts_i.last) begin
          state_d = S_OUT;
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = S_RD;
        end
      end
      S_FH: begin
        cmd_o.hold_en = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_NEXT;
        state_d       = S_FM;
      end
      S_FM: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_FREE;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // response valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/core/first_fit_heap_allocator.sv */
// Sequence: query and allocate are accepted, then each visited header is read
// and examined; a split writes the shrunk header back in its own state, and
// the response is loaded. Free reads its header and the next, then writes.
// Throughput: one transaction at a time, set by the walk of the header chain
// through the single read port of the header memory.
// Reset: one free block covering the whole heap, no clearing pass needed.
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap manager with block split on allocate and forward merge on
// free, over a header memory chained in address order.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator import ffha_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  ffha_in_if.sink   req_i,
  ffha_out_if.source rsp_o
);

  cmd_t cmd;
  sts_t sts;

  ffha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .out_valid_o(rsp_o.valid),
    .out_ready_i(rsp_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffha_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .op_i             (req_i.op),
    .request_size_i   (req_i.request_size),
    .payload_address_i(req_i.payload_address),
    .granted_address_o(rsp_o.granted_address),
    .no_space_o       (rsp_o.no_space),
    .free_bytes_o     (rsp_o.free_bytes)
  );

endmodule

/* test/first_fit_heap_allocator_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// Self-checking bench for the first-fit heap allocator. Directed cases hit the
// edges (whole-heap grants, impossible requests, forward merge, out-of-range
// release, the unused opcode), then a long random mix of allocate, release and
// query runs with random gaps on both channels. A heap model inside the bench
// predicts every response, which is compared field by field in order.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_tb;
  import ffha_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 3000000;
  localparam int         TAIL_CYCLES = 40;

  typedef struct packed {
    logic [ADDR_W-1:0] granted_address;
    logic              no_space;
    logic [SIZE_W-1:0] free_bytes;
  } rsp_t;

  logic clk;
  logic rst_ni;

  ffha_in_if  req_if ();
  ffha_out_if rsp_if ();

  first_fit_heap_allocator dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // heap image kept by the bench
  int heap_size [HEAP_BYTES];
  bit heap_free [HEAP_BYTES];
  int heap_next [HEAP_BYTES];

  rsp_t expected_rsp [$];
  int   live_blocks  [$];
  int   granted_hist [$];

  int  errors;
  int  cycle_count;
  int  rsp_count;
  int  n_alloc, n_free, n_query, n_nospace;
  bit  idle_en;
  int  hold_cycles;
  int  stall_left;
  bit  rsp_taken;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("first_fit_heap_allocator test failed");
      $finish;
    end
  end

  // heap model
  function automatic int next_header(int cur);
    int nx;
    nx = heap_next[cur];
    if (nx == 0 || nx >= HEAP_BYTES || nx <= cur) return 0;
    return nx;
  endfunction

  function automatic void model_reset();
    for (int i = 0; i < HEAP_BYTES; i++) begin
      heap_size[i] = 0;
      heap_free[i] = 1'b0;
      heap_next[i] = 0;
    end
    heap_size[0] = HEAP_BYTES;
    heap_free[0] = 1'b1;
  endfunction

  function automatic rsp_t model_step(logic [1:0] op, int req, int addr);
    rsp_t r;
    int   cur, need, rest, split, blk, nx, total;
    r = '0;
    case (op)
      OP_ALLOC: begin
        cur  = 0;
        need = req + HEADER_BYTES;
        r.no_space = 1'b1;
        forever begin
          if (heap_free[cur] && heap_size[cur] >= need) begin
            rest  = heap_size[cur] - need;
            split = cur + need;
            if (rest > HEADER_BYTES && split < HEAP_BYTES) begin
              heap_size[split] = rest;
              heap_free[split] = 1'b1;
              heap_next[split] = heap_next[cur];
              heap_size[cur]   = need;
              heap_next[cur]   = split;
            end
            heap_free[cur]    = 1'b0;
            r.no_space        = 1'b0;
            r.granted_address = ADDR_W'(cur + HEADER_BYTES);
            break;
          end
          cur = next_header(cur);
          if (cur == 0) break;
        end
      end
      OP_FREE: begin
        if (addr >= HEADER_BYTES) begin
          blk = addr - HEADER_BYTES;
          heap_free[blk] = 1'b1;
          nx = heap_next[blk];
          if (nx != 0 && nx < HEAP_BYTES && heap_free[nx]) begin
            total = heap_size[blk] + heap_size[nx];
            heap_size[blk] = (total > HEAP_BYTES) ? HEAP_BYTES : total;
            heap_next[blk] = heap_next[nx];
          end
        end
      end
      OP_QUERY: begin
        cur   = 0;
        total = 0;
        forever begin
          if (heap_free[cur]) begin
            total += heap_size[cur];
            if (total > HEAP_BYTES) total = HEAP_BYTES;
          end
          cur = next_header(cur);
          if (cur == 0) break;
        end
        r.free_bytes = SIZE_W'(total);
      end
      default: ;
    endcase
    return r;
  endfunction

  // response ready with random stalls and long hold-offs
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles   <= hold_cycles - 1;
      rsp_if.ready  <= 1'b0;
    end else if (rsp_taken) begin
      stall_left    = idle_en ? $urandom_range(0, 15) : 0;
      rsp_if.ready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_if.ready <= (stall_left == 0);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // response checker, sampled mid-cycle before the accepting edge
  always @(negedge clk) begin
    rsp_t e;
    rsp_taken = rst_ni && rsp_if.valid && rsp_if.ready;
    if (rsp_taken) begin
      rsp_count++;
      if (expected_rsp.size() == 0) begin
        $error("unexpected response transaction");
        errors++;
      end else begin
        e = expected_rsp.pop_front();
        if (rsp_if.granted_address !== e.granted_address) begin
          $error("granted_address expected %0d actual %0d",
                 e.granted_address, rsp_if.granted_address);
          errors++;
        end
        if (rsp_if.no_space !== e.no_space) begin
          $error("no_space expected %0d actual %0d", e.no_space, rsp_if.no_space);
          errors++;
        end
        if (rsp_if.free_bytes !== e.free_bytes) begin
          $error("free_bytes expected %0d actual %0d", e.free_bytes, rsp_if.free_bytes);
          errors++;
        end
      end
    end
  end

  // send one request transaction and record its prediction
  task automatic send_req(logic [1:0] op, int req, int addr);
    int   gap;
    rsp_t r;
    gap = idle_en ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid           <= 1'b1;
    req_if.op              <= op;
    req_if.request_size    <= ADDR_W'(req);
    req_if.payload_address <= ADDR_W'(addr);
    forever begin
      @(negedge clk);
      if (req_if.ready) begin
        @(posedge clk);
        break;
      end
      @(posedge clk);
    end
    r = model_step(op, req, addr);
    expected_rsp.push_back(r);
    case (op)
      OP_ALLOC: begin
        n_alloc++;
        if (r.no_space) n_nospace++;
        else begin
          live_blocks.push_back(r.granted_address);
          granted_hist.push_back(r.granted_address);
        end
      end
      OP_FREE:  n_free++;
      OP_QUERY: n_query++;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic free_live(int idx);
    int a;
    a = live_blocks[idx];
    live_blocks.delete(idx);
    send_req(OP_FREE, $urandom, a);
  endtask

  // edges: whole heap, impossible sizes, merge, range checks, unused opcode
  task automatic test_directed();
    send_req(OP_QUERY, 16'hFFFF, 16'hFFFF);
    send_req(OP_ALLOC, 65535, 0);
    send_req(OP_ALLOC, HEAP_BYTES - HEADER_BYTES, 16'hFFFF);
    send_req(OP_ALLOC, 0, 0);
    send_req(OP_QUERY, 0, 0);
    free_live(0);
    send_req(OP_QUERY, 0, 0);
    send_req(OP_FREE, 0, 0);
    send_req(OP_FREE, 0, HEADER_BYTES - 1);
    send_req(OP_UNUSED, 16'hFFFF, 16'hFFFF);
    send_req(OP_ALLOC, 0, 0);
    send_req(OP_ALLOC, 100, 0);
    send_req(OP_ALLOC, 32000, 0);
    send_req(OP_ALLOC, 32000, 0);
    send_req(OP_ALLOC, 1, 0);
    send_req(OP_QUERY, 0, 0);
    // middle then front: merge goes forward only
    free_live(2);
    free_live(1);
    send_req(OP_QUERY, 0, 0);
    // exact fit into the merged hole, no split
    send_req(OP_ALLOC, 32112 + 12 - HEADER_BYTES, 0);
    send_req(OP_ALLOC, 40000, 0);
    while (live_blocks.size() > 0) free_live(live_blocks.size() - 1);
    send_req(OP_QUERY, 0, 0);
    wait_drained();
  endtask

  // random mix of operations over a fragmented heap
  task automatic test_random(int count);
    int pick, sz, k;
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) idle_en = (i % 400 == 0) ? 1'b1 : 1'b0;
      pick = $urandom_range(0, 99);
      if (live_blocks.size() > 60 && pick < 50) pick = 50;
      if (pick < 45) begin
        k  = $urandom_range(0, 99);
        sz = (k < 80) ? $urandom_range(0, 255) :
             (k < 97) ? $urandom_range(0, 4095) : $urandom_range(0, 65535);
        send_req(OP_ALLOC, sz, $urandom);
      end else if (pick < 85 && live_blocks.size() > 0) begin
        free_live($urandom_range(0, live_blocks.size() - 1));
      end else if (pick < 95) begin
        send_req(OP_QUERY, $urandom, $urandom);
      end else if (pick < 97) begin
        send_req(OP_FREE, $urandom, $urandom_range(0, HEADER_BYTES - 1));
      end else if (pick < 98 && granted_hist.size() > 0) begin
        // release of an address handed out earlier, possibly stale
        send_req(OP_FREE, $urandom,
                 granted_hist[$urandom_range(0, granted_hist.size() - 1)]);
      end else begin
        send_req(OP_UNUSED, $urandom, $urandom);
      end
    end
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    idle_en = 1'b0;
    hold_cycles <= 400;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 2 && live_blocks.size() > 0) free_live(0);
      else send_req(i % 4 == 3 ? OP_QUERY : OP_ALLOC, $urandom_range(0, 63), 0);
    end
    wait_drained();
    idle_en = 1'b1;
  endtask

  // sender waits for every response before each transaction
  task automatic test_sender_pause();
    for (int i = 0; i < 10; i++) begin
      send_req(i % 2 ? OP_QUERY : OP_ALLOC, $urandom_range(0, 511), 0);
      wait_drained();
    end
  endtask

  initial begin
    rst_ni                 = 1'b0;
    req_if.valid           = 1'b0;
    req_if.op              = OP_QUERY;
    req_if.request_size    = '0;
    req_if.payload_address = '0;
    rsp_if.ready           = 1'b0;
    errors = 0; cycle_count = 0; rsp_count = 0; hold_cycles = 0; stall_left = 0;
    n_alloc = 0; n_free = 0; n_query = 0; n_nospace = 0;
    idle_en = 1'b1;
    model_reset();
    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_sender_pause();
    test_random(1300);

    $display("covered %0d allocations (%0d without space), %0d releases, %0d queries",
             n_alloc, n_nospace, n_free, n_query);
    $display("%0d responses checked in %0d cycles", rsp_count, cycle_count);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("first_fit_heap_allocator test passed");
    end else begin
      $display("first_fit_heap_allocator test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/ffha_pkg.sv
rtl/core/ffha_in_if.sv
rtl/core/ffha_out_if.sv
rtl/core/ffha_ram.sv
rtl/core/ffha_dp.sv
rtl/core/ffha_ctrl.sv
rtl/core/first_fit_heap_allocator.sv
test/first_fit_heap_allocator_tb.sv
